FILE: src/etrs_pkg.sv
// ----------------------------------------------------------------------------
// etrs_pkg: shared types and constants of the event time rank sorter
// Field widths, kind codes, rank classes, queue entry and back-end states.
// ----------------------------------------------------------------------------
package etrs_pkg;

    localparam int TIME_W          = 24;
    localparam int KIND_W          = 3;
    localparam int TAG_W           = 16;
    localparam int RANK_W          = 2;
    localparam int STORE_DEPTH_DEF = 64;
    localparam int QUEUE_DEPTH     = 4;

    typedef logic [KIND_W-1:0] t_kind;
    typedef logic [RANK_W-1:0] t_rank;

    localparam t_kind KIND_OTHER   = 3'd0;
    localparam t_kind KIND_NOTE_ON = 3'd1;
    localparam t_kind KIND_OFF     = 3'd2;
    localparam t_kind KIND_CHOKE   = 3'd3;
    localparam t_kind KIND_END     = 3'd4;

    localparam t_rank RANK_RELEASE = 2'd0;
    localparam t_rank RANK_OTHER   = 2'd1;
    localparam t_rank RANK_ATTACK  = 2'd2;

    typedef struct packed {
        logic [TIME_W-1:0] event_time;
        t_kind             event_kind;
        logic [TAG_W-1:0]  event_tag;
    } t_slot;

    typedef struct packed {
        t_slot slot;
        t_rank rank;
        logic  last;
    } t_entry;

    typedef enum logic {
        ST_COLLECT,
        ST_EMIT
    } t_back_state;

    function automatic t_rank kind_rank(input t_kind kind);
        t_rank rank;
        unique case (kind)
            KIND_OFF, KIND_CHOKE, KIND_END: rank = RANK_RELEASE;
            KIND_NOTE_ON:                   rank = RANK_ATTACK;
            default:                        rank = RANK_OTHER;
        endcase
        return rank;
    endfunction

endpackage

FILE: src/etrs_if.sv
// ----------------------------------------------------------------------------
// etrs_if: channel interfaces of the event time rank sorter
// Valid/ready channels for incoming events and for sorted results.
// ----------------------------------------------------------------------------
interface etrs_in_if
    import etrs_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] event_time;
    t_kind             event_kind;
    logic [TAG_W-1:0]  event_tag;
    logic              batch_last;

    modport source (output valid, event_time, event_kind, event_tag, batch_last,
                    input ready);
    modport sink   (input valid, event_time, event_kind, event_tag, batch_last,
                    output ready);
endinterface

interface etrs_out_if
    import etrs_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] sorted_time;
    t_kind             sorted_kind;
    logic [TAG_W-1:0]  sorted_tag;
    logic              run_last;
    logic              dropped;

    modport source (output valid, sorted_time, sorted_kind, sorted_tag, run_last, dropped,
                    input ready);
    modport sink   (input valid, sorted_time, sorted_kind, sorted_tag, run_last, dropped,
                    output ready);
endinterface

FILE: src/etrs_front.sv
// ----------------------------------------------------------------------------
// etrs_front: event intake stage
// Registers each incoming transaction and tags it with its kind rank.
// ----------------------------------------------------------------------------
module etrs_front
    import etrs_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    etrs_in_if.sink i_evt,
    output logic   o_push_valid,
    output t_entry o_push_data,
    input  logic   i_push_ready
);

    logic   r_valid;
    t_entry r_entry;
    t_entry n_entry;

    assign i_evt.ready = !r_valid || i_push_ready;

    always_comb begin
        n_entry.slot.event_time = i_evt.event_time;
        n_entry.slot.event_kind = i_evt.event_kind;
        n_entry.slot.event_tag  = i_evt.event_tag;
        n_entry.rank            = kind_rank(i_evt.event_kind);
        n_entry.last            = i_evt.batch_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_evt.ready) begin
            r_valid <= i_evt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_evt.valid && i_evt.ready) begin
            r_entry <= n_entry;
        end
    end

    assign o_push_valid = r_valid;
    assign o_push_data  = r_entry;

endmodule

FILE: src/etrs_queue.sv
// ----------------------------------------------------------------------------
// etrs_queue: decoupling FIFO between intake and sorter back end
// Small circular buffer of classified events.
// ----------------------------------------------------------------------------
module etrs_queue
    import etrs_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push_valid,
    input  t_entry i_push_data,
    output logic   o_push_ready,
    output logic   o_pop_valid,
    output t_entry o_pop_data,
    input  logic   i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               push;
    logic               pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

FILE: src/etrs_back.sv
// ----------------------------------------------------------------------------
// etrs_back: insertion chain and sorted run emitter
// Inserts events into a sorted register chain (one per cycle while collecting,
// dropped when full) and on batch close shifts it out via the output register.
// ----------------------------------------------------------------------------
module etrs_back
    import etrs_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_pop_valid,
    input  t_entry i_pop_data,
    output logic   o_pop,
    etrs_out_if.source o_srt
);

    localparam int CNT_W = $clog2(STORE_DEPTH + 1);
    localparam int KEY_W = TIME_W + RANK_W;

    t_back_state        r_state;
    t_back_state        n_state;
    t_slot              r_cell [STORE_DEPTH];
    logic [CNT_W-1:0]   r_count;
    logic               r_ovf;
    logic               r_out_valid;
    t_slot              r_out_slot;
    logic               r_out_last;
    logic               r_out_drop;

    logic               pop;
    logic               insert;
    logic               emit;
    logic               out_free;
    logic               count_one;
    logic [KEY_W-1:0]   new_key;
    logic               gt [STORE_DEPTH];

    assign out_free  = !r_out_valid || o_srt.ready;
    assign count_one = (r_count == CNT_W'(1));
    assign new_key   = {i_pop_data.slot.event_time, i_pop_data.rank};

    always_comb begin
        for (int i = 0; i < STORE_DEPTH; i++) begin
            gt[i] = (CNT_W'(i) < r_count) &&
                    ({r_cell[i].event_time, kind_rank(r_cell[i].event_kind)} > new_key);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_COLLECT: begin
                if (pop && i_pop_data.last) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit && count_one) begin
                    n_state = ST_COLLECT;
                end
            end
            default: n_state = ST_COLLECT;
        endcase
    end

    always_comb begin
        pop    = 1'b0;
        insert = 1'b0;
        emit   = 1'b0;
        unique case (r_state)
            ST_COLLECT: begin
                pop    = i_pop_valid;
                insert = i_pop_valid && (r_count != CNT_W'(STORE_DEPTH));
            end
            ST_EMIT: begin
                emit = out_free;
            end
            default: begin
                pop = 1'b0;
            end
        endcase
    end

    assign o_pop = pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_COLLECT;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (insert) begin
                r_count <= r_count + 1'b1;
            end else if (emit) begin
                r_count <= r_count - 1'b1;
            end
            if (pop && !insert) begin
                r_ovf <= 1'b1;
            end else if (emit && count_one) begin
                r_ovf <= 1'b0;
            end
            if (out_free) begin
                r_out_valid <= emit;
            end
        end
    end

    // shift up behind the insertion point, drop the new event into the gap
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < STORE_DEPTH; i++) begin
            if (insert) begin
                if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
                    r_cell[i] <= r_cell[(i > 0) ? i - 1 : 0];
                end else if (gt[i] || (CNT_W'(i) == r_count)) begin
                    r_cell[i] <= i_pop_data.slot;
                end
            end else if (emit && (i < STORE_DEPTH - 1)) begin
                r_cell[i] <= r_cell[(i < STORE_DEPTH - 1) ? i + 1 : i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_slot <= r_cell[0];
            r_out_last <= count_one;
            r_out_drop <= r_ovf;
        end
    end

    assign o_srt.valid       = r_out_valid;
    assign o_srt.sorted_time = r_out_slot.event_time;
    assign o_srt.sorted_kind = r_out_slot.event_kind;
    assign o_srt.sorted_tag  = r_out_slot.event_tag;
    assign o_srt.run_last    = r_out_last;
    assign o_srt.dropped     = r_out_drop;

endmodule

FILE: src/event_time_rank_sorter.sv
// ----------------------------------------------------------------------------
// event_time_rank_sorter: stable sorter of timed note events
// Collects a batch, keeps it ordered by time then kind rank, emits it on close.
// Throughput: one event per cycle while collecting; insertion chain takes one
//   event each cycle while collecting; runs leave one event per output transaction.
// Path: after the closing event is accepted, it passes the intake register,
//   queue write and insertion before the run's first result is registered out.
// Reset: synchronous, active low; clears control state, the store needs no clearing.
// ----------------------------------------------------------------------------
module event_time_rank_sorter
    import etrs_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    etrs_in_if.sink     i_evt,
    etrs_out_if.source  o_srt
);

    logic   push_valid;
    logic   push_ready;
    t_entry push_data;
    logic   pop_valid;
    logic   pop;
    t_entry pop_data;

    etrs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_evt        (i_evt),
        .o_push_valid (push_valid),
        .o_push_data  (push_data),
        .i_push_ready (push_ready)
    );

    etrs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_data  (push_data),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_data   (pop_data),
        .i_pop        (pop)
    );

    etrs_back #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .i_pop_data  (pop_data),
        .o_pop       (pop),
        .o_srt       (o_srt)
    );

endmodule
